// ===== rtl/clfp_pkg.sv =====
// Shared types and constants of the cursor list free pool.
package clfp_pkg;

	localparam int ELEM_W = 8;
	localparam int STAT_W = 2;
	localparam int SLOT_W = 3;

	// Operation codes carried on the func field.
	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_SEARCH = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FOUND    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_MISSING  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_EMIT
	} clfp_state_t;

	// One list entry as it moves down the row of cells on an insert.
	typedef struct packed {
		logic              used;
		logic [ELEM_W-1:0] data;
	} clfp_node_t;

	// The search probe handed from cell to cell.
	typedef struct packed {
		logic              tok;
		logic              hit;
		logic [ELEM_W-1:0] key;
	} clfp_probe_t;

endpackage

// ===== rtl/cursor_list_free_pool_top.sv =====
// Top level of the cursor list free pool: front-insert list with a byte search.
//
// The block keeps a fixed pool of SLOTS node slots. Slots are handed out from
// the top slot downward and are never returned, so the list is held as a row
// of identical cells in list order: an insert shifts every entry one cell
// further along and places the new byte in the first cell, which is exactly
// linking the new slot in front of the list head. An insert transaction puts
// its result in a pending register, which moves on to the output register
// once that is free; when every slot is taken the insert is refused with the
// full status and changes nothing. A search transaction launches a probe
// into the first cell, and the probe moves one cell per cycle, gathering a
// hit flag, until it reaches the tail of the list; its result enters the
// pending register there (at once for an empty list) and then the output
// register. One transaction is worked on at a time, and the next one is taken
// in the cycle after the result has moved into the output register. The
// result is then held in that output register, and a new input transaction
// is accepted while an earlier result still waits there to be taken.
module cursor_list_free_pool_top
	import clfp_pkg::*;
#(
	parameter int SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              func,
	input  logic [ELEM_W-1:0] elem,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [SLOT_W-1:0] slot
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	clfp_state_t state_q;
	clfp_state_t state_d;

	// Number of free slots; the next slot handed out is one below this count.
	logic [CNT_W-1:0]  free_len_q;
	logic [IDX_W-1:0]  free_slot;

	logic              accept;
	logic              out_free;
	logic              shift;
	logic              start;
	logic              pend_load;
	logic [STAT_W-1:0] pend_status_d;
	logic [SLOT_W-1:0] pend_slot_d;
	logic [STAT_W-1:0] pend_status_q;
	logic [SLOT_W-1:0] pend_slot_q;
	logic              out_load;
	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [SLOT_W-1:0] out_slot_q;

	// Chain wiring: entry 0 feeds the first cell, entry i+1 leaves cell i.
	clfp_node_t        node_c  [SLOTS+1];
	clfp_probe_t       probe_c [SLOTS+1];
	logic [SLOTS-1:0]  done_vec;
	logic [SLOTS-1:0]  hit_vec;
	logic              any_done;
	logic              any_hit;
	logic              head_used;

	assign node_c[0].used  = 1'b1;
	assign node_c[0].data  = elem;
	assign probe_c[0].tok  = start;
	assign probe_c[0].hit  = 1'b0;
	assign probe_c[0].key  = elem;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		logic nxt_used;

		if (i == SLOTS - 1) begin : g_last
			assign nxt_used = 1'b0;
		end else begin : g_mid
			assign nxt_used = node_c[i+2].used;
		end

		clfp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.shift     (shift),
			.node_in   (node_c[i]),
			.node_out  (node_c[i+1]),
			.probe_in  (probe_c[i]),
			.probe_out (probe_c[i+1]),
			.next_used (nxt_used),
			.done      (done_vec[i])
		);

		assign hit_vec[i] = probe_c[i+1].hit;
	end

	// Only one cell can hold the probe, so a plain OR picks out its flags.
	assign any_done  = |done_vec;
	assign any_hit   = |(done_vec & hit_vec);
	assign head_used = node_c[1].used;

	assign free_slot = IDX_W'(free_len_q - CNT_W'(1));
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			free_len_q <= CNT_W'(SLOTS);
		end else begin
			state_q <= state_d;
			if (shift) begin
				free_len_q <= free_len_q - CNT_W'(1);
			end
		end
	end

	always_comb begin
		state_d       = state_q;
		shift         = 1'b0;
		start         = 1'b0;
		pend_load     = 1'b0;
		pend_status_d = STAT_MISSING;
		pend_slot_d   = '0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (func == FUNC_INSERT) begin
						pend_load = 1'b1;
						state_d   = ST_EMIT;
						if (free_len_q == '0) begin
							pend_status_d = STAT_FULL;
						end else begin
							shift         = 1'b1;
							pend_status_d = STAT_INSERTED;
							pend_slot_d   = SLOT_W'(free_slot);
						end
					end else if (!head_used) begin
						// Empty list: nothing to walk.
						pend_load     = 1'b1;
						pend_status_d = STAT_MISSING;
						state_d       = ST_EMIT;
					end else begin
						start   = 1'b1;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (any_done) begin
					pend_load     = 1'b1;
					pend_status_d = any_hit ? STAT_FOUND : STAT_MISSING;
					state_d       = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_status_q <= pend_status_d;
			pend_slot_q   <= pend_slot_d;
		end
		if (out_load) begin
			out_status_q <= pend_status_q;
			out_slot_q   <= pend_slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign slot      = out_slot_q;

endmodule

// ===== rtl/clfp_cell.sv =====
// One cell of the list row: holds one listed byte and passes the search probe on.
module clfp_cell
	import clfp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        shift,
	input  clfp_node_t  node_in,
	output clfp_node_t  node_out,
	input  clfp_probe_t probe_in,
	output clfp_probe_t probe_out,
	input  logic        next_used,
	output logic        done
);

	logic              used_q;
	logic [ELEM_W-1:0] byte_q;
	logic              tok_q;
	logic              hit_q;
	logic [ELEM_W-1:0] key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			tok_q  <= 1'b0;
			hit_q  <= 1'b0;
		end else begin
			if (shift) begin
				used_q <= node_in.used;
			end
			// The probe only settles in a cell that holds a listed entry.
			tok_q <= probe_in.tok & used_q;
			hit_q <= probe_in.hit | (used_q & (byte_q == probe_in.key));
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= node_in.data;
		end
		key_q <= probe_in.key;
	end

	assign node_out.used  = used_q;
	assign node_out.data  = byte_q;
	assign probe_out.tok  = tok_q;
	assign probe_out.hit  = hit_q;
	assign probe_out.key  = key_q;

	// The probe has reached the tail of the list when the next cell is empty.
	assign done = tok_q & ~next_used;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the cursor list free pool: directed and random insert and search.
module testbench
	import clfp_pkg::*;
();

	localparam int CLK_PERIOD   = 12;
	localparam int SLOTS        = 8;
	localparam int N_RANDOM     = 500;
	// Idling profile: each phase spans this many transactions on its side.
	localparam int PHASE_LEN    = 170;
	// The receiver holds off once, for a long stretch, after this many results.
	localparam int HOLD_AT      = 400;
	localparam int HOLD_CYCLES  = 64;
	// The sender stops once, after this many transactions, until all results are in.
	localparam int PAUSE_AT     = 450;
	localparam int MAX_SHOWN    = 10;
	// A search walks at most SLOTS cells.
	localparam int DRAIN_CYCLES = SLOTS + 8;
	localparam int LIMIT_CYCLES = 200000;

	typedef struct packed {
		logic              func;
		logic [ELEM_W-1:0] elem;
	} pool_op_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
	} pool_result_t;

	// The directed opening: searches of an empty list, a search that hits the
	// only entry, then the pool is filled (a repeated byte among the entries),
	// inserts are refused once it is full, and searches reach the head, the
	// tail, the middle and bytes that are absent.
	localparam int N_DIRECTED = 21;
	localparam pool_op_t DIRECTED [N_DIRECTED] = '{
		{FUNC_SEARCH, 8'h00}, {FUNC_SEARCH, 8'hFF},
		{FUNC_INSERT, 8'h00}, {FUNC_SEARCH, 8'h00}, {FUNC_SEARCH, 8'h01},
		{FUNC_INSERT, 8'hFF}, {FUNC_INSERT, 8'h80}, {FUNC_INSERT, 8'h01},
		{FUNC_INSERT, 8'h7F}, {FUNC_INSERT, 8'h55}, {FUNC_INSERT, 8'hAA},
		{FUNC_INSERT, 8'h00},
		{FUNC_INSERT, 8'hFF}, {FUNC_INSERT, 8'h12},
		{FUNC_SEARCH, 8'h00}, {FUNC_SEARCH, 8'hFF}, {FUNC_SEARCH, 8'h55},
		{FUNC_SEARCH, 8'hAA}, {FUNC_SEARCH, 8'h80}, {FUNC_SEARCH, 8'h13},
		{FUNC_SEARCH, 8'hFE}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid;
	logic              in_stall;
	logic              func;
	logic [ELEM_W-1:0] elem;
	logic              out_valid;
	logic              out_stall;
	logic [STAT_W-1:0] status;
	logic [SLOT_W-1:0] slot;

	// Transactions still to be offered, and results still owed by the block.
	pool_op_t     pending_ops [$];
	pool_result_t owed_results [$];

	// Private copy of the pool contents. Slots are handed out from the top
	// down and never returned, so entry i of stored_bytes sits in slot
	// SLOTS-1-i and the count of used slots says everything about both lists.
	logic [ELEM_W-1:0] stored_bytes [SLOTS];
	int                used_slots;

	int n_sent;
	int n_taken;
	int hold_left;
	bit hold_done;
	int failures;

	cursor_list_free_pool_top #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.elem     (elem),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.slot     (slot)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Works out the result of one transaction and advances the private pool.
	function automatic pool_result_t pool_outcome(logic op, logic [ELEM_W-1:0] byte_in);
		pool_result_t r;
		int i;
		r.status = STAT_MISSING;
		r.slot = '0;
		if (op == FUNC_INSERT) begin
			if (used_slots == SLOTS) begin
				r.status = STAT_FULL;
			end else begin
				r.status = STAT_INSERTED;
				r.slot = SLOT_W'(SLOTS - 1 - used_slots);
				stored_bytes[used_slots] = byte_in;
				used_slots++;
			end
		end else begin
			for (i = 0; i < used_slots; i++)
				if (stored_bytes[i] == byte_in)
					r.status = STAT_FOUND;
		end
		return r;
	endfunction

	// Driver. An accepted transaction is predicted on the edge that accepts
	// it. A new one is offered only when the input register is free, so a
	// stalled payload never changes. The sender idles with a chance of 21 percent
	// in the first phase, 80 percent in the second and never afterwards; once,
	// after PAUSE_AT transactions, it waits until the block has handed back
	// every result it owes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_INSERT;
			elem <= '0;
			n_sent = 0;
			used_slots = 0;
		end else begin
			if (in_valid && !in_stall) begin
				owed_results.push_back(pool_outcome(func, elem));
				n_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_ops.size() == 0
						|| (n_sent == PAUSE_AT && owed_results.size() != 0)
						|| (n_sent < PHASE_LEN && $urandom_range(99) < 21)
						|| (n_sent >= PHASE_LEN && n_sent < 2 * PHASE_LEN
							&& $urandom_range(99) < 80)) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					{func, elem} <= pending_ops.pop_front();
				end
			end
		end
	end

	// Monitor. Each result transaction is checked against the oldest owed
	// result. The receiver stalls with a chance of 80 percent in the first phase,
	// 21 percent in the second and never afterwards, except for one long hold-off
	// that lets the block fill up and push back on its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			n_taken = 0;
			hold_left = 0;
			hold_done = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_taken++;
				if (owed_results.size() == 0) begin
					failures++;
					if (failures <= MAX_SHOWN)
						$display("result %0d arrived with none owed: status %0d slot %0d",
							n_taken, status, slot);
				end else if (owed_results[0].status !== status
						|| owed_results[0].slot !== slot) begin
					failures++;
					if (failures <= MAX_SHOWN)
						$display("result %0d: expected status %0d slot %0d, got status %0d slot %0d",
							n_taken, owed_results[0].status, owed_results[0].slot,
							status, slot);
					void'(owed_results.pop_front());
				end else begin
					void'(owed_results.pop_front());
				end
			end
			if (!hold_done && n_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (n_taken < PHASE_LEN) begin
				out_stall <= ($urandom_range(99) < 80);
			end else if (n_taken < 2 * PHASE_LEN) begin
				out_stall <= ($urandom_range(99) < 21);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus and end of run. The directed part fills the pool, so from
	// then on every insert is refused and the random searches walk the full
	// list; most of them look for a byte from the directed inserts, the
	// rest for any byte at all.
	initial begin : stimulus
		logic [ELEM_W-1:0] known_bytes [$];
		pool_op_t op;
		int k;
		failures = 0;
		for (k = 0; k < N_DIRECTED; k++) begin
			pending_ops.push_back(DIRECTED[k]);
			if (DIRECTED[k].func == FUNC_INSERT)
				known_bytes.push_back(DIRECTED[k].elem);
		end
		for (k = 0; k < N_RANDOM; k++) begin
			op.func = ($urandom_range(99) < 12) ? FUNC_INSERT : FUNC_SEARCH;
			if (op.func == FUNC_SEARCH && $urandom_range(99) < 55)
				op.elem = known_bytes[$urandom_range(known_bytes.size() - 1)];
			else
				op.elem = ELEM_W'($urandom);
			pending_ops.push_back(op);
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (pending_ops.size() != 0 || in_valid)
			@(posedge clk);
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && owed_results.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run here.
	initial begin : watchdog
		#(LIMIT_CYCLES * CLK_PERIOD);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== cursor_list_free_pool_top.f =====
rtl/clfp_pkg.sv
rtl/clfp_cell.sv
rtl/cursor_list_free_pool_top.sv
verif/testbench.sv
